// File: rtl/core/moa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_pkg: shared types and codes for the memory ownership admission engine
// Request opcodes, status codes, register indexes and the control word
// passed from the update logic to the top level.
// ----------------------------------------------------------------------------
package moa_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADKIND   = 2'd3
  } status_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ADMISSION_EN = 3'd0,
    CFG_TARGET_LIMIT = 3'd1,
    CFG_RESIZE_ACT   = 3'd2,
    CFG_RESIZE_TGT   = 3'd3,
    CFG_FREE_FLOOR   = 3'd4
  } cfg_idx_e;

  // Fixed field widths
  localparam int unsigned FieldWidth = 48;
  localparam int unsigned KindWidth  = 4;
  localparam int unsigned CountWidth = 32;

  // Update control word
  typedef struct packed {
    status_e status;
    logic    upd;      // state changes: write back entry and totals
    logic    refused;  // bump refusal counter
  } upd_ctl_t;

endpackage

// File: rtl/core/moa_admit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_admit: reserve admission check
// Evaluates overflow, target and free-floor limits from the totals and the
// request word, and registers the verdict at accept time.
// ----------------------------------------------------------------------------
module moa_admit import moa_pkg::*; #(
  parameter int unsigned BW = 48
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic [BW-1:0]         resident_i,
  input  logic [BW-1:0]         pending_i,
  input  logic [FieldWidth-1:0] bytes_i,
  input  logic                  optional_i,
  input  logic [FieldWidth-1:0] physical_free_i,
  input  logic                  admission_en_i,
  input  logic [FieldWidth-1:0] target_limit_i,
  input  logic                  resize_active_i,
  input  logic [FieldWidth-1:0] resize_target_i,
  input  logic [FieldWidth-1:0] free_floor_i,
  output logic                  refused_o
);

  // Wide enough for a three-operand sum of the widest values
  localparam int unsigned SW = ((BW > FieldWidth) ? BW : FieldWidth) + 2;

  logic [SW-1:0] sum_all;
  logic [SW-1:0] sum_floor;
  logic [SW-1:0] byte_max;
  logic [FieldWidth-1:0] target;
  logic ovf, over_tgt, over_floor;
  logic refused_d, refused_q;

  // resident + pending + bytes against the count range and the active target;
  // pending + bytes + floor against sampled free bytes
  always_comb begin
    byte_max   = SW'({BW{1'b1}});
    target     = resize_active_i ? resize_target_i : target_limit_i;
    sum_all    = SW'(resident_i) + SW'(pending_i) + SW'(bytes_i);
    sum_floor  = SW'(pending_i) + SW'(bytes_i) + SW'(free_floor_i);
    ovf        = sum_all > byte_max;
    over_tgt   = sum_all > SW'(target);
    over_floor = sum_floor > SW'(physical_free_i);
    refused_d  = ovf | (optional_i & admission_en_i & (over_tgt | over_floor));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      refused_q <= refused_d;
    end
  end

  assign refused_o = refused_q;

endmodule

// File: rtl/core/moa_kind_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_kind_mem: per-category counter memory
// One row per category holding pending and resident bytes, registered
// read. Per-row valid bits make unwritten rows read as zero.
// ----------------------------------------------------------------------------
module moa_kind_mem #(
  parameter int unsigned BW        = 48,
  parameter int unsigned NUM_KINDS = 8,
  parameter int unsigned KW        = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [KW-1:0] rd_addr_i,
  output logic [BW-1:0] rd_pending_o,
  output logic [BW-1:0] rd_resident_o,
  input  logic          wr_en_i,
  input  logic [KW-1:0] wr_addr_i,
  input  logic [BW-1:0] wr_pending_i,
  input  logic [BW-1:0] wr_resident_i
);

  logic [BW-1:0] pend_mem [NUM_KINDS];
  logic [BW-1:0] res_mem  [NUM_KINDS];
  logic [NUM_KINDS-1:0] vld_q;
  logic [BW-1:0] pend_rd_q, res_rd_q;
  logic rd_vld_q;

  // Storage write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pend_mem[wr_addr_i] <= wr_pending_i;
      res_mem[wr_addr_i]  <= wr_resident_i;
    end
    if (rd_en_i) begin
      pend_rd_q <= pend_mem[rd_addr_i];
      res_rd_q  <= res_mem[rd_addr_i];
    end
  end

  // Row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_pending_o  = rd_vld_q ? pend_rd_q : '0;
  assign rd_resident_o = rd_vld_q ? res_rd_q  : '0;

endmodule

// File: rtl/core/moa_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moa_update: read-modify-write datapath
// Applies one request to the category row and the totals: underflow checks,
// new counter values and the control word for write back.
// ----------------------------------------------------------------------------
module moa_update import moa_pkg::*; #(
  parameter int unsigned BW = 48
) (
  input  op_e                   op_i,
  input  logic                  kind_ok_i,
  input  logic                  refused_i,
  input  logic [FieldWidth-1:0] bytes_i,
  input  logic [BW-1:0]         kind_pending_i,
  input  logic [BW-1:0]         kind_resident_i,
  input  logic [BW-1:0]         pending_i,
  input  logic [BW-1:0]         resident_i,
  output logic [BW-1:0]         kind_pending_o,
  output logic [BW-1:0]         kind_resident_o,
  output logic [BW-1:0]         pending_o,
  output logic [BW-1:0]         resident_o,
  output upd_ctl_t              ctl_o
);

  localparam int unsigned CW = ((BW > FieldWidth) ? BW : FieldWidth) + 1;

  logic [CW-1:0] b_w, kp_w, kr_w, pt_w, rt_w;
  logic [CW-1:0] kp_add, pt_add, kr_add, rt_add;
  logic [CW-1:0] kp_sub, pt_sub, kr_sub, rt_sub;

  always_comb begin
    b_w    = CW'(bytes_i);
    kp_w   = CW'(kind_pending_i);
    kr_w   = CW'(kind_resident_i);
    pt_w   = CW'(pending_i);
    rt_w   = CW'(resident_i);
    kp_add = kp_w + b_w;
    pt_add = pt_w + b_w;
    kr_add = kr_w + b_w;
    rt_add = rt_w + b_w;
    kp_sub = kp_w - b_w;
    pt_sub = pt_w - b_w;
    kr_sub = kr_w - b_w;
    rt_sub = rt_w - b_w;

    // default: nothing changes
    kind_pending_o  = kind_pending_i;
    kind_resident_o = kind_resident_i;
    pending_o       = pending_i;
    resident_o      = resident_i;
    ctl_o.status    = ST_OK;
    ctl_o.upd       = 1'b0;
    ctl_o.refused   = 1'b0;

    if (!kind_ok_i) begin
      ctl_o.status = ST_BADKIND;
    end else begin
      case (op_i)
        OP_RESERVE: begin
          if (refused_i) begin
            ctl_o.status  = ST_REFUSED;
            ctl_o.refused = 1'b1;
          end else begin
            ctl_o.upd      = 1'b1;
            kind_pending_o = kp_add[BW-1:0];
            pending_o      = pt_add[BW-1:0];
          end
        end
        OP_COMMIT, OP_CANCEL: begin
          if (kp_w < b_w || pt_w < b_w) begin
            ctl_o.status = ST_UNDERFLOW;
          end else begin
            ctl_o.upd      = 1'b1;
            kind_pending_o = kp_sub[BW-1:0];
            pending_o      = pt_sub[BW-1:0];
            // commit moves the bytes to resident
            if (op_i == OP_COMMIT) begin
              kind_resident_o = kr_add[BW-1:0];
              resident_o      = rt_add[BW-1:0];
            end
          end
        end
        OP_RELEASE: begin
          if (kr_w < b_w || rt_w < b_w) begin
            ctl_o.status = ST_UNDERFLOW;
          end else begin
            ctl_o.upd       = 1'b1;
            kind_resident_o = kr_sub[BW-1:0];
            resident_o      = rt_sub[BW-1:0];
          end
        end
        default: begin
          ctl_o.status = ST_OK;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/memory_ownership_admission_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_ownership_admission_top: byte-ownership accounting engine
// Result word registered when the accepted request writes back. One request
// at a time (category row read, then modify and write back through the
// counter memory); a stalled output word holds the write back. Reset clears
// totals, refusal count, config and row valids.
// ----------------------------------------------------------------------------
module memory_ownership_admission_top import moa_pkg::*; #(
  parameter int unsigned NUM_KINDS  = 8,
  parameter int unsigned BYTE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [FieldWidth-1:0]  cfg_data_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             op_i,
  input  logic [KindWidth-1:0]   kind_i,
  input  logic [FieldWidth-1:0]  bytes_i,
  input  logic                   optional_i,
  input  logic [FieldWidth-1:0]  physical_free_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [FieldWidth-1:0]  total_resident_o,
  output logic [FieldWidth-1:0]  total_pending_o,
  output logic [CountWidth-1:0]  refusal_count_o
);

  localparam int unsigned BW = BYTE_WIDTH;
  localparam int unsigned KW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int unsigned CW = ((BW > FieldWidth) ? BW : FieldWidth) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic                  adm_en_q;
  logic [FieldWidth-1:0] target_limit_q;
  logic                  resize_act_q;
  logic [FieldWidth-1:0] resize_tgt_q;
  logic [FieldWidth-1:0] free_floor_q;

  // totals and refusal counter
  logic [BW-1:0]         resident_q, pending_q;
  logic [CountWidth-1:0] refusals_q;

  // captured request word
  op_e                   op_q;
  logic [KW-1:0]         kidx_q;
  logic                  kind_ok_q;
  logic [FieldWidth-1:0] bytes_q;

  // output register
  logic                  out_valid_q;
  status_e               status_q;
  logic [FieldWidth-1:0] tot_res_q, tot_pend_q;
  logic [CountWidth-1:0] ref_cnt_q;

  logic          in_acc, commit, refused;
  logic [BW-1:0] rd_pend, rd_res;
  logic [BW-1:0] new_kp, new_kr, new_pt, new_rt;
  logic [CW-1:0] new_pt_w, new_rt_w;
  logic [CountWidth-1:0] refusals_d;
  upd_ctl_t      ctl;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & (state_q == S_IDLE);
  assign commit      = (state_q == S_EXEC) & (~out_valid_q | ~out_stall_i);

  // sequencer: read row, then modify and write back once the output is free
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adm_en_q       <= 1'b0;
      target_limit_q <= '0;
      resize_act_q   <= 1'b0;
      resize_tgt_q   <= '0;
      free_floor_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ADMISSION_EN: adm_en_q       <= cfg_data_i[0];
        CFG_TARGET_LIMIT: target_limit_q <= cfg_data_i;
        CFG_RESIZE_ACT:   resize_act_q   <= cfg_data_i[0];
        CFG_RESIZE_TGT:   resize_tgt_q   <= cfg_data_i;
        CFG_FREE_FLOOR:   free_floor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture request word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= op_e'(op_i);
      kidx_q    <= kind_i[KW-1:0];
      kind_ok_q <= ({1'b0, kind_i} < (KindWidth + 1)'(NUM_KINDS));
      bytes_q   <= bytes_i;
    end
  end

  // reserve admission verdict, evaluated against the totals at accept
  moa_admit #(
    .BW (BW)
  ) u_admit (
    .clk_i           (clk_i),
    .load_i          (in_acc),
    .resident_i      (resident_q),
    .pending_i       (pending_q),
    .bytes_i         (bytes_i),
    .optional_i      (optional_i),
    .physical_free_i (physical_free_i),
    .admission_en_i  (adm_en_q),
    .target_limit_i  (target_limit_q),
    .resize_active_i (resize_act_q),
    .resize_target_i (resize_tgt_q),
    .free_floor_i    (free_floor_q),
    .refused_o       (refused)
  );

  // per-category counters
  moa_kind_mem #(
    .BW        (BW),
    .NUM_KINDS (NUM_KINDS),
    .KW        (KW)
  ) u_kind_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (in_acc),
    .rd_addr_i     (kind_i[KW-1:0]),
    .rd_pending_o  (rd_pend),
    .rd_resident_o (rd_res),
    .wr_en_i       (commit & ctl.upd),
    .wr_addr_i     (kidx_q),
    .wr_pending_i  (new_kp),
    .wr_resident_i (new_kr)
  );

  moa_update #(
    .BW (BW)
  ) u_update (
    .op_i            (op_q),
    .kind_ok_i       (kind_ok_q),
    .refused_i       (refused),
    .bytes_i         (bytes_q),
    .kind_pending_i  (rd_pend),
    .kind_resident_i (rd_res),
    .pending_i       (pending_q),
    .resident_i      (resident_q),
    .kind_pending_o  (new_kp),
    .kind_resident_o (new_kr),
    .pending_o       (new_pt),
    .resident_o      (new_rt),
    .ctl_o           (ctl)
  );

  // saturating refusal count
  always_comb begin
    refusals_d = refusals_q;
    if (ctl.refused && refusals_q != {CountWidth{1'b1}}) begin
      refusals_d = refusals_q + CountWidth'(1);
    end
  end

  // totals and refusal counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident_q <= '0;
      pending_q  <= '0;
      refusals_q <= '0;
    end else if (commit) begin
      resident_q <= new_rt;
      pending_q  <= new_pt;
      refusals_q <= refusals_d;
    end
  end

  // result word register
  assign new_pt_w = CW'(new_pt);
  assign new_rt_w = CW'(new_rt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q   <= ctl.status;
      tot_res_q  <= new_rt_w[FieldWidth-1:0];
      tot_pend_q <= new_pt_w[FieldWidth-1:0];
      ref_cnt_q  <= refusals_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign total_resident_o = tot_res_q;
  assign total_pending_o  = tot_pend_q;
  assign refusal_count_o  = ref_cnt_q;

endmodule
